// ===== rtl/lattice_path_count_with_blocks_macros.svh =====
// ----------------------------------------------------------------------------
// Lattice path counter assertion macros
// Shared property wrappers for the lattice path counter; they compile to
// nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LATTICE_PATH_COUNT_WITH_BLOCKS_MACROS_SVH
`define LATTICE_PATH_COUNT_WITH_BLOCKS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPCB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define LPCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LPCB_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define LPCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/lpcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Lattice path counter package
// Modulus, item modes and the types shared by the counter and its multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lpcb_pkg;

   localparam int VAL_W = 30;
   localparam logic [VAL_W-1:0] MOD_P = 30'd1000000007;
   localparam logic [VAL_W-1:0] FERMAT_EXP = 30'd1000000005;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_COUNT = 1'b1;

   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] value;
   } mul_rsp_type;

   typedef struct packed {
      logic [VAL_W-1:0] fact;
      logic [VAL_W-1:0] inv;
   } tbl_entry_type;

endpackage

// ===== rtl/lattice_path_count_with_blocks.sv =====
// ----------------------------------------------------------------------------
// Lattice path counter with blocked cells
// Counts right/down paths across a configured grid that avoid loaded blocked
// cells, modulo 1000000007, using factorial tables and inclusion-exclusion.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. A load item
// (mode 0) inserts one blocked cell into a sorted list held in a memory; it
// keeps busy high while it shifts larger cells up and gives no result.
// A count item (mode 1) walks all ordered pairs of stored cells; each pair
// that needs a binomial reads the table memory and uses the modular
// multiplier, and busy stays high for the whole pass. Its result shows on
// the rsp_ ports for one cycle with rsp_valid, as the block returns to
// idle; the receiver cannot stall it. After reset the block builds the
// factorial and inverse factorial tables with busy high; grid registers on
// the APB-style port can be written and read at any time, but are read by
// a count pass only when it runs. Reset clears the stored cells and the
// overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lattice_path_count_with_blocks_macros.svh"
module lattice_path_count_with_blocks #(
   parameter int MAX_DIM    = 1024,
   parameter int MAX_WALLS  = 256,
   parameter int FACT_DEPTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [10:0] req_cell_row,
   input  logic [10:0] req_cell_col,
   output logic        rsp_valid,
   output logic [29:0] rsp_path_count,
   output logic        rsp_wall_overflow,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int TW = $clog2(FACT_DEPTH);
   localparam int CW = $clog2(MAX_WALLS + 1);
   localparam int WA = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
   localparam int VW = lpcb_pkg::VAL_W;

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_INIT      = 5'd1;
   localparam logic [4:0] ST_BF_MUL    = 5'd2;
   localparam logic [4:0] ST_BF_WAIT   = 5'd3;
   localparam logic [4:0] ST_PW_ACC    = 5'd4;
   localparam logic [4:0] ST_PW_ACCW   = 5'd5;
   localparam logic [4:0] ST_PW_SQ     = 5'd6;
   localparam logic [4:0] ST_PW_SQW    = 5'd7;
   localparam logic [4:0] ST_BB_RD     = 5'd8;
   localparam logic [4:0] ST_BB_WAIT   = 5'd9;
   localparam logic [4:0] ST_LD_RD     = 5'd10;
   localparam logic [4:0] ST_LD_CMP    = 5'd11;
   localparam logic [4:0] ST_NXT       = 5'd12;
   localparam logic [4:0] ST_TGT_GET   = 5'd13;
   localparam logic [4:0] ST_W0        = 5'd14;
   localparam logic [4:0] ST_W1        = 5'd15;
   localparam logic [4:0] ST_W2        = 5'd16;
   localparam logic [4:0] ST_W3        = 5'd17;
   localparam logic [4:0] ST_W4        = 5'd18;
   localparam logic [4:0] ST_W5        = 5'd19;
   localparam logic [4:0] ST_TGT_DONE  = 5'd20;
   localparam logic [4:0] ST_PR_RD     = 5'd21;
   localparam logic [4:0] ST_PR_CHK    = 5'd22;
   localparam logic [4:0] ST_PAIR_MUL  = 5'd23;
   localparam logic [4:0] ST_PAIR_WAIT = 5'd24;

   typedef struct packed {
      logic [DW-1:0] row;
      logic [DW-1:0] col;
      logic [VW-1:0] part;
   } wall_type;

   lpcb_pkg::tbl_entry_type tbl_mem [FACT_DEPTH];
   wall_type                wall_mem [MAX_WALLS];

   logic [4:0]    state_ff, state_in, ret_ff, ret_in;
   logic [TW-1:0] idx_ff, idx_in;
   logic [4:0]    bit_ff, bit_in;
   logic [VW-1:0] fact_ff, fact_in, base_ff, base_in, acc_ff, acc_in;
   logic [VW-1:0] inva_ff, inva_in, invb_ff, invb_in, topf_ff, topf_in;
   logic [VW-1:0] wres_ff, wres_in, part_ff, part_in;
   logic [CW-1:0] cnt_ff, cnt_in, pos_ff, pos_in, k_ff, k_in;
   logic [CW-1:0] i_ff, i_in, lim_ff, lim_in;
   logic          last_ff, last_in, ovf_ff, ovf_in;
   logic [DW-1:0] tr_ff, tr_in, tc_ff, tc_in, wdr_ff, wdr_in, wdc_ff, wdc_in;
   logic [DW-1:0] ldr_ff, ldr_in, ldc_ff, ldc_in;
   logic [10:0]   grid_rows_ff, grid_cols_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_count_ff, rsp_count_in;

   logic                    tbl_we, tbl_re;
   logic [TW-1:0]           tbl_waddr, tbl_raddr;
   lpcb_pkg::tbl_entry_type tbl_wdata, tbl_rd_ff;
   logic                    wall_we, wall_re;
   logic [WA-1:0]           wall_waddr, wall_raddr;
   wall_type                wall_wdata, wall_rd_ff;

   lpcb_pkg::mul_req_type mul_req;
   lpcb_pkg::mul_rsp_type mul_rsp;

   logic          accept, cell_ok, cfg_wr;
   logic [31:0]   rows_w, cols_w, rows_c, cols_c;
   logic [DW-1:0] er, ec;
   logic [DW:0]   top;
   logic [VW:0]   acc_sub;

   lpcb_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign prdata = {21'd0, paddr[2] ? grid_cols_ff : grid_rows_ff};

   assign rows_w = 32'(grid_rows_ff);
   assign cols_w = 32'(grid_cols_ff);
   assign rows_c = (rows_w == 32'd0) ? 32'd1 : ((rows_w > MAX_DIM) ? MAX_DIM : rows_w);
   assign cols_c = (cols_w == 32'd0) ? 32'd1 : ((cols_w > MAX_DIM) ? MAX_DIM : cols_w);
   assign er     = DW'(rows_c - 32'd1);
   assign ec     = DW'(cols_c - 32'd1);
   assign cell_ok = (req_cell_row != 11'd0) && (req_cell_col != 11'd0) &&
                    (32'(req_cell_row) <= MAX_DIM) && (32'(req_cell_col) <= MAX_DIM);
   assign top     = {1'b0, wdr_ff} + {1'b0, wdc_ff};
   assign acc_sub = (acc_ff >= mul_rsp.value) ? {1'b0, acc_ff - mul_rsp.value}
                    : {1'b0, acc_ff} + {1'b0, lpcb_pkg::MOD_P - mul_rsp.value};

   always_comb begin
      state_in = state_ff;  ret_in  = ret_ff;   idx_in  = idx_ff;   bit_in  = bit_ff;
      fact_in  = fact_ff;   base_in = base_ff;  acc_in  = acc_ff;
      inva_in  = inva_ff;   invb_in = invb_ff;  topf_in = topf_ff;
      wres_in  = wres_ff;   part_in = part_ff;
      cnt_in   = cnt_ff;    pos_in  = pos_ff;   k_in    = k_ff;
      i_in     = i_ff;      lim_in  = lim_ff;   last_in = last_ff;  ovf_in = ovf_ff;
      tr_in    = tr_ff;     tc_in   = tc_ff;    wdr_in  = wdr_ff;   wdc_in = wdc_ff;
      ldr_in   = ldr_ff;    ldc_in  = ldc_ff;
      rsp_valid_in = 1'b0;  rsp_count_in = rsp_count_ff;
      tbl_we = 1'b0;  tbl_waddr = '0;  tbl_wdata = '0;  tbl_re = 1'b0;  tbl_raddr = '0;
      wall_we = 1'b0; wall_waddr = '0; wall_wdata = '0; wall_re = 1'b0; wall_raddr = '0;
      mul_req = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == lpcb_pkg::MODE_COUNT) begin
                  k_in     = '0;
                  state_in = ST_NXT;
               end else if (cell_ok) begin
                  if (32'(cnt_ff) >= MAX_WALLS) begin
                     ovf_in = 1'b1;
                  end else begin
                     ldr_in   = DW'(req_cell_row - 11'd1);
                     ldc_in   = DW'(req_cell_col - 11'd1);
                     pos_in   = cnt_ff;
                     state_in = ST_LD_RD;
                  end
               end
            end
         end
         ST_INIT: begin
            tbl_we    = 1'b1;
            tbl_waddr = '0;
            tbl_wdata = '{fact: VW'(1), inv: VW'(1)};
            fact_in   = VW'(1);
            idx_in    = TW'(1);
            state_in  = ST_BF_MUL;
         end
         ST_BF_MUL: begin
            mul_req  = '{start: 1'b1, a: VW'(idx_ff), b: fact_ff};
            state_in = ST_BF_WAIT;
         end
         ST_BF_WAIT: begin
            if (mul_rsp.done) begin
               fact_in   = mul_rsp.value;
               tbl_we    = 1'b1;
               tbl_waddr = idx_ff;
               tbl_wdata = '{fact: mul_rsp.value, inv: '0};
               if (32'(idx_ff) == FACT_DEPTH - 1) begin
                  acc_in   = VW'(1);
                  base_in  = mul_rsp.value;
                  bit_in   = '0;
                  state_in = ST_PW_ACC;
               end else begin
                  idx_in   = idx_ff + TW'(1);
                  state_in = ST_BF_MUL;
               end
            end
         end
         ST_PW_ACC: begin
            mul_req  = '{start: 1'b1, a: acc_ff, b: base_ff};
            state_in = ST_PW_ACCW;
         end
         ST_PW_ACCW: begin
            if (mul_rsp.done) begin
               if (lpcb_pkg::FERMAT_EXP[bit_ff]) begin
                  acc_in = mul_rsp.value;
               end
               state_in = ST_PW_SQ;
            end
         end
         ST_PW_SQ: begin
            mul_req  = '{start: 1'b1, a: base_ff, b: base_ff};
            state_in = ST_PW_SQW;
         end
         ST_PW_SQW: begin
            if (mul_rsp.done) begin
               base_in = mul_rsp.value;
               if (bit_ff == 5'(VW - 1)) begin
                  tbl_we    = 1'b1;
                  tbl_waddr = idx_ff;
                  tbl_wdata = '{fact: fact_ff, inv: acc_ff};
                  state_in  = ST_BB_RD;
               end else begin
                  bit_in   = bit_ff + 5'd1;
                  state_in = ST_PW_ACC;
               end
            end
         end
         ST_BB_RD: begin
            tbl_re    = 1'b1;
            tbl_raddr = idx_ff - TW'(1);
            mul_req   = '{start: 1'b1, a: acc_ff, b: VW'(idx_ff)};
            state_in  = ST_BB_WAIT;
         end
         ST_BB_WAIT: begin
            if (mul_rsp.done) begin
               acc_in    = mul_rsp.value;
               tbl_we    = 1'b1;
               tbl_waddr = idx_ff - TW'(1);
               tbl_wdata = '{fact: tbl_rd_ff.fact, inv: mul_rsp.value};
               if (idx_ff == TW'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - TW'(1);
                  state_in = ST_BB_RD;
               end
            end
         end
         ST_LD_RD: begin
            if (pos_ff == '0) begin
               wall_we    = 1'b1;
               wall_waddr = '0;
               wall_wdata = '{row: ldr_ff, col: ldc_ff, part: '0};
               cnt_in     = cnt_ff + CW'(1);
               state_in   = ST_IDLE;
            end else begin
               wall_re    = 1'b1;
               wall_raddr = WA'(pos_ff - CW'(1));
               state_in   = ST_LD_CMP;
            end
         end
         ST_LD_CMP: begin
            wall_we    = 1'b1;
            wall_waddr = WA'(pos_ff);
            if ((wall_rd_ff.row < ldr_ff) ||
                ((wall_rd_ff.row == ldr_ff) && (wall_rd_ff.col <= ldc_ff))) begin
               wall_wdata = '{row: ldr_ff, col: ldc_ff, part: '0};
               cnt_in     = cnt_ff + CW'(1);
               state_in   = ST_IDLE;
            end else begin
               wall_wdata = wall_rd_ff;
               pos_in     = pos_ff - CW'(1);
               state_in   = ST_LD_RD;
            end
         end
         ST_NXT: begin
            if (k_ff < cnt_ff) begin
               wall_re    = 1'b1;
               wall_raddr = WA'(k_ff);
               state_in   = ST_TGT_GET;
            end else begin
               tr_in    = er;
               tc_in    = ec;
               wdr_in   = er;
               wdc_in   = ec;
               lim_in   = cnt_ff;
               last_in  = 1'b1;
               ret_in   = ST_TGT_DONE;
               state_in = ST_W0;
            end
         end
         ST_TGT_GET: begin
            tr_in    = wall_rd_ff.row;
            tc_in    = wall_rd_ff.col;
            wdr_in   = wall_rd_ff.row;
            wdc_in   = wall_rd_ff.col;
            lim_in   = k_ff;
            last_in  = 1'b0;
            ret_in   = ST_TGT_DONE;
            state_in = ST_W0;
         end
         ST_W0: begin
            if (32'(top) >= FACT_DEPTH) begin
               wres_in  = '0;
               state_in = ret_ff;
            end else begin
               tbl_re    = 1'b1;
               tbl_raddr = TW'(wdr_ff);
               state_in  = ST_W1;
            end
         end
         ST_W1: begin
            inva_in   = tbl_rd_ff.inv;
            tbl_re    = 1'b1;
            tbl_raddr = TW'(wdc_ff);
            state_in  = ST_W2;
         end
         ST_W2: begin
            invb_in   = tbl_rd_ff.inv;
            tbl_re    = 1'b1;
            tbl_raddr = TW'(top);
            state_in  = ST_W3;
         end
         ST_W3: begin
            topf_in  = tbl_rd_ff.fact;
            mul_req  = '{start: 1'b1, a: inva_ff, b: invb_ff};
            state_in = ST_W4;
         end
         ST_W4: begin
            if (mul_rsp.done) begin
               mul_req  = '{start: 1'b1, a: topf_ff, b: mul_rsp.value};
               state_in = ST_W5;
            end
         end
         ST_W5: begin
            if (mul_rsp.done) begin
               wres_in  = mul_rsp.value;
               state_in = ret_ff;
            end
         end
         ST_TGT_DONE: begin
            acc_in   = wres_ff;
            i_in     = '0;
            state_in = ST_PR_RD;
         end
         ST_PR_RD: begin
            if (i_ff == lim_ff) begin
               if (last_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = acc_ff;
                  state_in     = ST_IDLE;
               end else begin
                  wall_we    = 1'b1;
                  wall_waddr = WA'(k_ff);
                  wall_wdata = '{row: tr_ff, col: tc_ff, part: acc_ff};
                  k_in       = k_ff + CW'(1);
                  state_in   = ST_NXT;
               end
            end else begin
               wall_re    = 1'b1;
               wall_raddr = WA'(i_ff);
               state_in   = ST_PR_CHK;
            end
         end
         ST_PR_CHK: begin
            if ((wall_rd_ff.row <= tr_ff) && (wall_rd_ff.col <= tc_ff)) begin
               part_in  = wall_rd_ff.part;
               wdr_in   = tr_ff - wall_rd_ff.row;
               wdc_in   = tc_ff - wall_rd_ff.col;
               ret_in   = ST_PAIR_MUL;
               state_in = ST_W0;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = ST_PR_RD;
            end
         end
         ST_PAIR_MUL: begin
            mul_req  = '{start: 1'b1, a: part_ff, b: wres_ff};
            state_in = ST_PAIR_WAIT;
         end
         ST_PAIR_WAIT: begin
            if (mul_rsp.done) begin
               acc_in   = acc_sub[VW-1:0];
               i_in     = i_ff + CW'(1);
               state_in = ST_PR_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
      if (wall_we) begin
         wall_mem[wall_waddr] <= wall_wdata;
      end
      if (wall_re) begin
         wall_rd_ff <= wall_mem[wall_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         grid_rows_ff <= 11'd1024;
         grid_cols_ff <= 11'd1024;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr && !paddr[2]) begin
            grid_rows_ff <= pwdata[10:0];
         end
         if (cfg_wr && paddr[2]) begin
            grid_cols_ff <= pwdata[10:0];
         end
      end
      ret_ff  <= ret_in;   idx_ff  <= idx_in;   bit_ff  <= bit_in;
      fact_ff <= fact_in;  base_ff <= base_in;  acc_ff  <= acc_in;
      inva_ff <= inva_in;  invb_ff <= invb_in;  topf_ff <= topf_in;
      wres_ff <= wres_in;  part_ff <= part_in;
      pos_ff  <= pos_in;   k_ff    <= k_in;     i_ff    <= i_in;
      lim_ff  <= lim_in;   last_ff <= last_in;
      tr_ff   <= tr_in;    tc_ff   <= tc_in;    wdr_ff  <= wdr_in;  wdc_ff <= wdc_in;
      ldr_ff  <= ldr_in;   ldc_ff  <= ldc_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_path_count    = rsp_count_ff;
   assign rsp_wall_overflow = ovf_ff;

   `LPCB_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result beat while busy")
   `LPCB_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, 32'(cnt_ff) <= MAX_WALLS, "blocked cell count past capacity")
   `LPCB_ASSERT_NEXT(a_ovf_sticky, clock, reset, ovf_ff, ovf_ff, "overflow flag cleared without reset")
endmodule

// ===== rtl/lpcb_mulmod.sv =====
// ----------------------------------------------------------------------------
// Modular multiplier
// Five-stage Barrett multiplier: product, quotient estimate, quotient times
// modulus, and two conditional subtractions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lattice_path_count_with_blocks_macros.svh"
module lpcb_mulmod (
   input  logic                 clock,
   input  logic                 reset,
   input  lpcb_pkg::mul_req_type mul_req,
   output lpcb_pkg::mul_rsp_type mul_rsp
);
   localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'(lpcb_pkg::MOD_P);
   localparam logic [30:0] MU = MU_WIDE[30:0];
   localparam logic [31:0] P32 = 32'(lpcb_pkg::MOD_P);

   logic [4:0]  vld_ff, vld_in;
   logic [59:0] prod_ff, prod_in;
   logic [30:0] q3_ff, q3_in;
   logic [31:0] xlo2_ff, xlo3_ff;
   logic [31:0] qp_ff, qp_in;
   logic [31:0] r1_ff, r1_in;
   logic [29:0] res_ff, res_in;
   logic [61:0] q2_full;
   logic [60:0] qp_full;
   logic [31:0] r0;
   logic [31:0] r2;

   assign prod_in = mul_req.a * mul_req.b;
   assign q2_full = prod_ff[59:29] * MU;
   assign q3_in   = q2_full[61:31];
   assign qp_full = q3_ff * lpcb_pkg::MOD_P;
   assign qp_in   = qp_full[31:0];
   assign r0      = xlo3_ff - qp_ff;
   assign r1_in   = (r0 >= P32) ? r0 - P32 : r0;
   assign r2      = (r1_ff >= P32) ? r1_ff - P32 : r1_ff;
   assign res_in  = r2[29:0];
   assign vld_in  = {vld_ff[3:0], mul_req.start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      prod_ff <= prod_in;
      q3_ff   <= q3_in;
      xlo2_ff <= prod_ff[31:0];
      qp_ff   <= qp_in;
      xlo3_ff <= xlo2_ff;
      r1_ff   <= r1_in;
      res_ff  <= res_in;
   end

   assign mul_rsp.done  = vld_ff[4];
   assign mul_rsp.value = res_ff;

   `LPCB_ASSERT_SAME(a_res_reduced, clock, reset, mul_rsp.done, mul_rsp.value < lpcb_pkg::MOD_P, "multiplier result not reduced")
   `LPCB_ASSERT_SAME(a_done_latency, clock, reset, mul_rsp.done, $past(mul_req.start, 5), "multiplier done without start")
   `LPCB_ASSERT_SAME(a_single_op, clock, reset, mul_req.start, vld_ff[3:0] == 4'd0, "multiplier started while busy")
endmodule
